// ===== sv/speed_profile_interpolator_macros.svh =====
// assertion macros for the speed profile interpolator
// expects clk and rst_n in the scope of use
`ifndef SPEED_PROFILE_INTERPOLATOR_MACROS_SVH
`define SPEED_PROFILE_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SPI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SPI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SPI_ASSERT_IMP(label, ante, cons)
`define SPI_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== sv/spi_pkg.sv =====
// shared types, codes and sizes of the speed profile interpolator
// no dependencies
`timescale 1ns / 1ps
package spi_pkg;
  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIV_STEPS  = 33;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_EVAL   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FEW   = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_ORDER = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef logic signed [31:0] val_t;

  typedef struct packed {
    logic [31:0] tm;
    val_t [3:0]  v;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd_srch;
    logic srch_cmp;
    logic rd_a;
    logic cap_a;
    logic rd_b;
    logic cap_b;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic div_fin;
    logic load_out;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic eval_go;
    logic search_done;
    logic lo_zero;
    logic div_last;
    logic last_val;
    logic out_free;
  } sts_t;
endpackage

// ===== sv/spi_if.sv =====
// request and result channel interfaces
// depends on spi_pkg
`timescale 1ns / 1ps
interface spi_in_if;
  import spi_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] time_point;
  val_t        distance;
  val_t        speed;
  val_t        accel;
  val_t        jerk;
  modport source (output valid, cmd, time_point, distance, speed, accel, jerk, input ready);
  modport sink (input valid, cmd, time_point, distance, speed, accel, jerk, output ready);
endinterface

interface spi_out_if;
  import spi_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_time;
  val_t        out_distance;
  val_t        out_speed;
  val_t        out_accel;
  val_t        out_jerk;
  logic [31:0] total_time;
  modport source (output valid, status, out_time, out_distance, out_speed, out_accel,
                  out_jerk, total_time, input ready);
  modport sink (input valid, status, out_time, out_distance, out_speed, out_accel,
                out_jerk, total_time, output ready);
endinterface

// ===== sv/spi_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module spi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/spi_ctrl.sv =====
// sequencing state machine of the interpolator
// depends on spi_pkg
`timescale 1ns / 1ps
module spi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spi_pkg::sts_t sts,
  output spi_pkg::ctl_t ctl
);
  import spi_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SRCH  = 12'b000000000010,
    S_SRWT  = 12'b000000000100,
    S_RDA   = 12'b000000001000,
    S_RDAW  = 12'b000000010000,
    S_RDBW  = 12'b000000100000,
    S_MUL1  = 12'b000001000000,
    S_MUL2  = 12'b000010000000,
    S_DINIT = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_DFIN  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = sts.eval_go ? S_SRCH : S_OUT;
        end
      end
      S_SRCH: begin
        if (sts.search_done) begin
          state_nxt = S_RDA;
        end else begin
          ctl.rd_srch = 1'b1;
          state_nxt   = S_SRWT;
        end
      end
      S_SRWT: begin
        ctl.srch_cmp = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_RDA: begin
        ctl.rd_a  = 1'b1;
        state_nxt = S_RDAW;
      end
      S_RDAW: begin
        ctl.cap_a = 1'b1;
        if (sts.lo_zero) begin
          state_nxt = S_OUT;
        end else begin
          ctl.rd_b  = 1'b1;
          state_nxt = S_RDBW;
        end
      end
      S_RDBW: begin
        ctl.cap_b = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        ctl.mul_lo = 1'b1;
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        ctl.mul_hi = 1'b1;
        state_nxt  = S_DINIT;
      end
      S_DINIT: begin
        ctl.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        ctl.div_fin = 1'b1;
        state_nxt   = sts.last_val ? S_OUT : S_MUL1;
      end
      S_OUT: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== sv/spi_dp.sv =====
// datapath: point table, search, multiply, serial divide, result register
// depends on spi_pkg and spi_ram
`timescale 1ns / 1ps
module spi_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  spi_pkg::ctl_t ctl,
  output spi_pkg::sts_t sts,
  input  logic [1:0]    in_cmd,
  input  logic [31:0]   in_time,
  input  spi_pkg::val_t in_distance,
  input  spi_pkg::val_t in_speed,
  input  spi_pkg::val_t in_accel,
  input  spi_pkg::val_t in_jerk,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [2:0]    out_status,
  output logic [31:0]   out_time,
  output spi_pkg::val_t out_distance,
  output spi_pkg::val_t out_speed,
  output spi_pkg::val_t out_accel,
  output spi_pkg::val_t out_jerk,
  output logic [31:0]   out_total
);
  import spi_pkg::*;

  // table bookkeeping
  logic [CNT_W-1:0] count_r;
  logic [31:0]      first_r, last_r;
  // request latch
  logic [31:0]      t_r;
  logic [2:0]       status_r;
  logic             eval_ok_r;
  // search
  logic [CNT_W-1:0] lo_r, hi_r, mid_r, mid_c, lo_m1;
  // neighbours and arithmetic
  entry_t           a_r, b_r;
  logic [31:0]      dt_r, span_r;
  logic [1:0]       k_r;
  logic             neg_r;
  logic [47:0]      pp_lo_r;
  logic [48:0]      pp_hi_r;
  logic [31:0]      rem_r;
  logic [32:0]      dvd_r;
  logic [DCNT_W-1:0] dcnt_r;
  val_t [3:0]       res_r;
  // result register
  logic             out_valid_r;
  logic [2:0]       o_status_r;
  logic [31:0]      o_time_r, o_total_r;
  val_t [3:0]       o_val_r;

  logic             order_err, full_err, in_range, app_ok;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           wr_entry, rd_entry;
  logic signed [32:0] delta;
  logic [32:0]      mag;
  logic [64:0]      prod;
  logic [33:0]      trial;
  logic [33:0]      fin;

  // request checks
  assign order_err = (count_r != '0) && (last_r >= in_time);
  assign full_err  = (count_r >= CNT_W'(MAX_POINTS));
  assign in_range  = (in_time >= first_r) && (in_time <= last_r);
  assign app_ok    = ctl.accept && (in_cmd == CMD_APPEND) && !order_err && !full_err;

  assign sts.eval_go     = (in_cmd == CMD_EVAL) && (count_r >= CNT_W'(2)) && in_range;
  assign sts.search_done = (lo_r >= hi_r);
  assign sts.lo_zero     = (lo_r == '0);
  assign sts.div_last    = (dcnt_r == DCNT_W'(1));
  assign sts.last_val    = (k_r == 2'd3);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign mid_c = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_m1 = lo_r - CNT_W'(1);

  // table memory
  assign wr_entry.tm   = in_time;
  assign wr_entry.v[0] = in_distance;
  assign wr_entry.v[1] = in_speed;
  assign wr_entry.v[2] = in_accel;
  assign wr_entry.v[3] = in_jerk;
  assign ram_re = ctl.rd_srch || ctl.rd_a || ctl.rd_b;
  assign rd_entry = entry_t'(ram_rdata);

  always_comb begin
    ram_raddr = lo_r[IDX_W-1:0];
    if (ctl.rd_srch) begin
      ram_raddr = mid_c[IDX_W-1:0];
    end else if (ctl.rd_a) begin
      ram_raddr = (lo_r == '0) ? '0 : lo_m1[IDX_W-1:0];
    end
  end

  spi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (app_ok),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // magnitude of the neighbour difference
  assign delta = {b_r.v[k_r][31], b_r.v[k_r]} - {a_r.v[k_r][31], a_r.v[k_r]};
  assign mag   = delta[32] ? 33'(-delta) : 33'(delta);
  assign prod  = {pp_hi_r, 16'b0} + {17'b0, pp_lo_r};
  assign trial = {1'b0, rem_r, dvd_r[32]} - {2'b0, span_r};
  assign fin   = neg_r ? ({{2{a_r.v[k_r][31]}}, a_r.v[k_r]} - {1'b0, dvd_r})
                       : ({{2{a_r.v[k_r][31]}}, a_r.v[k_r]} + {1'b0, dvd_r});

  // table bookkeeping and search control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.accept) begin
      if (in_cmd == CMD_CLEAR) begin
        count_r <= '0;
      end else if (app_ok) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (app_ok) begin
      last_r <= in_time;
      if (count_r == '0) begin
        first_r <= in_time;
      end
    end
    if (ctl.accept) begin
      t_r       <= in_time;
      eval_ok_r <= sts.eval_go;
      lo_r      <= '0;
      hi_r      <= count_r;
      case (in_cmd)
        CMD_APPEND: status_r <= order_err ? ST_ORDER : (full_err ? ST_FULL : ST_OK);
        CMD_EVAL:   status_r <= (count_r < CNT_W'(2)) ? ST_FEW
                                : (in_range ? ST_OK : ST_RANGE);
        default:    status_r <= ST_OK;
      endcase
    end
    if (ctl.rd_srch) begin
      mid_r <= mid_c;
    end
    if (ctl.srch_cmp) begin
      if (rd_entry.tm < t_r) begin
        lo_r <= mid_r + CNT_W'(1);
      end else begin
        hi_r <= mid_r;
      end
    end
    // neighbour capture
    if (ctl.cap_a) begin
      a_r   <= rd_entry;
      res_r <= rd_entry.v;
      dt_r  <= t_r - rd_entry.tm;
      k_r   <= 2'd0;
    end
    if (ctl.cap_b) begin
      b_r    <= rd_entry;
      span_r <= rd_entry.tm - a_r.tm;
    end
    // split multiply
    if (ctl.mul_lo) begin
      pp_lo_r <= {32'b0, mag[15:0]} * {16'b0, dt_r};
      neg_r   <= delta[32];
    end
    if (ctl.mul_hi) begin
      pp_hi_r <= {32'b0, mag[32:16]} * {17'b0, dt_r};
    end
    // restoring divide, one quotient bit a cycle
    if (ctl.div_init) begin
      rem_r  <= prod[64:33];
      dvd_r  <= prod[32:0];
      dcnt_r <= DCNT_W'(DIV_STEPS);
    end
    if (ctl.div_step) begin
      rem_r  <= trial[33] ? {rem_r[30:0], dvd_r[32]} : trial[31:0];
      dvd_r  <= {dvd_r[31:0], !trial[33]};
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
    if (ctl.div_fin) begin
      res_r[k_r] <= fin[31:0];
      k_r        <= k_r + 2'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      o_status_r <= status_r;
      o_time_r   <= eval_ok_r ? t_r : '0;
      o_val_r    <= eval_ok_r ? res_r : '0;
      o_total_r  <= (count_r == '0) ? '0 : (last_r - first_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = o_status_r;
  assign out_time     = o_time_r;
  assign out_distance = o_val_r[0];
  assign out_speed    = o_val_r[1];
  assign out_accel    = o_val_r[2];
  assign out_jerk     = o_val_r[3];
  assign out_total    = o_total_r;
endmodule

// ===== sv/speed_profile_interpolator.sv =====
// channel   dir  handshake      payload
// in_ch     in   valid/ready    cmd, time_point, distance, speed, accel, jerk
// out_ch    out  valid/ready    status, out_time, four values, total_time
//
// one request at a time; append, clear and errors go from idle to the output state and
// load the result register; evaluate searches the table ram, then, unless the time is
// the first point, runs the 1 bit a cycle divider per value (4 values, 33 steps)
// synchronous active low reset empties the table; no clearing pass is needed
// a stalled result holds in the output register; the next request is taken, then waits
// Top level: controller, datapath; depends on spi_pkg, spi_if, macros header
`timescale 1ns / 1ps
`include "speed_profile_interpolator_macros.svh"
module speed_profile_interpolator (
  input logic       clk,
  input logic       rst_n,
  spi_in_if.sink    in_ch,
  spi_out_if.source out_ch
);
  import spi_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // controller
  spi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath
  spi_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .in_cmd       (in_ch.cmd),
    .in_time      (in_ch.time_point),
    .in_distance  (in_ch.distance),
    .in_speed     (in_ch.speed),
    .in_accel     (in_ch.accel),
    .in_jerk      (in_ch.jerk),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_status   (out_ch.status),
    .out_time     (out_ch.out_time),
    .out_distance (out_ch.out_distance),
    .out_speed    (out_ch.out_speed),
    .out_accel    (out_ch.out_accel),
    .out_jerk     (out_ch.out_jerk),
    .out_total    (out_ch.total_time)
  );

  // checks
  `SPI_ASSERT_NXT(a_busy_after_req, in_ch.valid && in_ch.ready, !in_ch.ready)
  `SPI_ASSERT_NXT(a_div_ends, ctl.div_step && sts.div_last, ctl.div_fin)
  `SPI_ASSERT_IMP(a_one_read, 1'b1, $onehot0({ctl.rd_srch, ctl.rd_a, ctl.rd_b}))
endmodule

// ===== verif/speed_profile_interpolator_tb.sv =====
// testbench for the speed profile interpolator: append, evaluate and clear requests
// checked against a local table model; depends on spi_pkg, spi_if and the block
`timescale 1ns / 1ps
class profile_scoreboard;
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] tm;
    logic [31:0] d, s, a, j;
    logic [31:0] total;
  } result_t;

  logic [31:0]        tab_time [256];
  logic signed [31:0] tab_val [256][4];
  int unsigned        count;
  result_t            pending [$];
  int                 mismatches;

  function new();
    count = 0;
    mismatches = 0;
  endfunction

  // exact truncated linear blend between two stored values
  function logic [31:0] blend(logic signed [31:0] x0, logic signed [31:0] x1,
                              longint unsigned dt, longint unsigned span);
    longint            delta;
    longint unsigned   mag, q;
    delta = longint'(x1) - longint'(x0);
    mag = (delta < 0) ? longint'(-delta) : delta;
    q = (mag * dt) / span;
    return (delta < 0) ? 32'(longint'(x0) - longint'(q)) : 32'(longint'(x0) + longint'(q));
  endfunction

  // note an accepted request and queue its expected result
  function void note_request(logic [1:0] cmd, logic [31:0] t, logic signed [31:0] v [4]);
    result_t r;
    int unsigned lo, hi, mid, pa;
    r = '0;
    r.status = spi_pkg::ST_OK;
    if (cmd == spi_pkg::CMD_APPEND) begin
      if (count > 0 && tab_time[count-1] >= t) r.status = spi_pkg::ST_ORDER;
      else if (count >= 256) r.status = spi_pkg::ST_FULL;
      else begin
        tab_time[count] = t;
        for (int k = 0; k < 4; k++) tab_val[count][k] = v[k];
        count++;
      end
    end else if (cmd == spi_pkg::CMD_EVAL) begin
      if (count < 2) r.status = spi_pkg::ST_FEW;
      else if (t < tab_time[0] || t > tab_time[count-1]) r.status = spi_pkg::ST_RANGE;
      else begin
        lo = 0;
        hi = count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (tab_time[mid] < t) lo = mid + 1;
          else hi = mid;
        end
        if (lo == 0) begin
          r.tm = tab_time[0];
          r.d = tab_val[0][0]; r.s = tab_val[0][1]; r.a = tab_val[0][2]; r.j = tab_val[0][3];
        end else begin
          pa = lo - 1;
          r.tm = t;
          r.d = blend(tab_val[pa][0], tab_val[lo][0], t - tab_time[pa],
                      tab_time[lo] - tab_time[pa]);
          r.s = blend(tab_val[pa][1], tab_val[lo][1], t - tab_time[pa],
                      tab_time[lo] - tab_time[pa]);
          r.a = blend(tab_val[pa][2], tab_val[lo][2], t - tab_time[pa],
                      tab_time[lo] - tab_time[pa]);
          r.j = blend(tab_val[pa][3], tab_val[lo][3], t - tab_time[pa],
                      tab_time[lo] - tab_time[pa]);
        end
      end
    end else if (cmd == spi_pkg::CMD_CLEAR) begin
      count = 0;
    end
    r.total = (count == 0) ? 32'd0 : tab_time[count-1] - tab_time[0];
    pending.insert(pending.size(), r);
  endfunction

  // compare one accepted result against the oldest expectation
  function void check_result(result_t got);
    result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected st=%0d t=%h d=%h s=%h a=%h j=%h tot=%h",
                 want.status, want.tm, want.d, want.s, want.a, want.j, want.total);
        $display("          got      st=%0d t=%h d=%h s=%h a=%h j=%h tot=%h",
                 got.status, got.tm, got.d, got.s, got.a, got.j, got.total);
      end
    end
  endfunction
endclass

module speed_profile_interpolator_tb;
  import spi_pkg::*;

  logic clk;
  logic rst_n;
  int   cycles;
  bit   no_idle;
  bit   long_hold;
  logic [31:0] last_time;

  spi_in_if  in_ch ();
  spi_out_if out_ch ();

  profile_scoreboard board;

  speed_profile_interpolator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result sampling
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.status, out_ch.out_time, out_ch.out_distance,
                          out_ch.out_speed, out_ch.out_accel, out_ch.out_jerk,
                          out_ch.total_time});
  end

  // request sampling
  always @(posedge clk) begin
    logic signed [31:0] v [4];
    if (rst_n && in_ch.valid && in_ch.ready) begin
      v[0] = in_ch.distance; v[1] = in_ch.speed; v[2] = in_ch.accel; v[3] = in_ch.jerk;
      board.note_request(in_ch.cmd, in_ch.time_point, v);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(negedge clk);
        long_hold = 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [31:0] t, logic [31:0] d, logic [31:0] s,
                      logic [31:0] a, logic [31:0] j);
    int n;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      in_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.cmd        = cmd;
    in_ch.time_point = t;
    in_ch.distance   = d;
    in_ch.speed      = s;
    in_ch.accel      = a;
    in_ch.jerk       = j;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // append a point with rising time, step chosen small or large
  task automatic append_rising();
    logic [31:0] step;
    step = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32'h00ffffff)
                                       : $urandom_range(1, 2000);
    if (last_time > 32'hffffffff - step) step = 1;
    last_time = last_time + step;
    send(CMD_APPEND, last_time, rnd_val(), rnd_val(), rnd_val(), rnd_val());
  endtask

  // query somewhere around the table span
  task automatic eval_random();
    logic [31:0] t;
    int unsigned c;
    c = board.count;
    case ($urandom_range(0, 9))
      0: t = $urandom;
      1: t = (c > 0) ? board.tab_time[0] : 0;
      2: t = (c > 0) ? board.tab_time[c-1] : 0;
      3: t = (c > 0) ? board.tab_time[$urandom_range(0, c-1)] : 0;
      default: t = (c > 1) ? 32'(longint'(board.tab_time[0]) +
                             {$urandom} % (longint'(board.tab_time[c-1]) -
                                           longint'(board.tab_time[0]) + 1)) : $urandom;
    endcase
    send(CMD_EVAL, t, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int sent;
    int r;
    board = new();
    cycles = 0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_APPEND;
    in_ch.time_point = '0;
    in_ch.distance = '0;
    in_ch.speed = '0;
    in_ch.accel = '0;
    in_ch.jerk = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, one point, endpoints, order errors, unused command, clear
    send(CMD_EVAL, 32'd0, 0, 0, 0, 0);
    send(CMD_APPEND, 32'd0, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'd1);
    send(CMD_EVAL, 32'd0, 0, 0, 0, 0);
    send(CMD_APPEND, 32'd0, 0, 0, 0, 0);
    send(CMD_APPEND, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'd1, 32'hffffffff);
    send(CMD_EVAL, 32'd0, 0, 0, 0, 0);
    send(CMD_EVAL, 32'hffffffff, 0, 0, 0, 0);
    send(CMD_EVAL, 32'h7fffffff, 0, 0, 0, 0);
    send(CMD_EVAL, 32'h80000000, 0, 0, 0, 0);
    send(CMD_APPEND, 32'hffffffff, 0, 0, 0, 0);
    send(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send(CMD_CLEAR, 32'h12345678, 0, 0, 0, 0);
    send(CMD_APPEND, 32'd100, 32'd10, 32'd20, 32'd30, 32'd40);
    send(CMD_APPEND, 32'd50, 0, 0, 0, 0);
    send(CMD_APPEND, 32'd200, 32'hfffffff6, 32'd20, 32'd0, 32'h7fffffff);
    send(CMD_EVAL, 32'd99, 0, 0, 0, 0);
    send(CMD_EVAL, 32'd201, 0, 0, 0, 0);
    send(CMD_EVAL, 32'd150, 0, 0, 0, 0);
    send(CMD_EVAL, 32'd199, 0, 0, 0, 0);

    // fill the table to capacity and push past it, with a long receiver hold-off
    send(CMD_CLEAR, 0, 0, 0, 0, 0);
    last_time = 0;
    drain();
    long_hold = 1'b1;
    for (int i = 0; i < 258; i++) append_rising();
    send(CMD_EVAL, last_time, 0, 0, 0, 0);
    eval_random();
    // sender pauses until every expected result has been received
    drain();

    // random mix: rebuild tables, mostly evaluate
    sent = 0;
    while (sent < 1320) begin
      if (sent > 1100) no_idle = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        last_time = $urandom_range(0, 1000) == 0 ? 32'hfffff000 : $urandom_range(0, 100000);
      end else if (r < 35) append_rising();
      else if (r < 38)
        send(CMD_APPEND, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 40) send(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
      else eval_random();
      sent++;
    end

    // wait for outstanding results, then a tail
    while (board.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== speed_profile_interpolator.f =====
+incdir+sv
sv/spi_pkg.sv
sv/spi_if.sv
sv/spi_ram.sv
sv/spi_ctrl.sv
sv/spi_dp.sv
sv/speed_profile_interpolator.sv
verif/speed_profile_interpolator_tb.sv
